### sv/assert_macros.svh
// Assertion macros shared by the priority queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (cons)) \
        else $error("implication check failed");

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### sv/pqmm_pkg.sv
// Shared constants and types of the priority queue core and its cells.
`default_nettype none

package pqmm_pkg;

    localparam int CAPACITY    = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(CAPACITY);

    // Operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_PEEK   = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Command broadcast to every cell of the row
    typedef enum logic [2:0] {
        CELL_HOLD  = 3'd0,
        CELL_INS   = 3'd1,
        CELL_SHL   = 3'd2,
        CELL_TRIM  = 3'd3,
        CELL_CLEAR = 3'd4
    } t_cell_op;

    typedef struct packed {
        t_cell_op                      op;
        logic signed [VALUE_WIDTH-1:0] value;
    } t_cell_ctl;

    // What one cell shows its neighbors
    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] val;
        logic                          vld;
        logic                          above;
    } t_cell_bus;

endpackage

`default_nettype wire

### sv/pqmm_cell.sv
// One cell of the sorted row: holds one entry, ascending from cell 0.
`default_nettype none
`include "assert_macros.svh"

module pqmm_cell (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire pqmm_pkg::t_cell_ctl  i_ctl,
    input  wire pqmm_pkg::t_cell_bus  i_left,
    input  wire pqmm_pkg::t_cell_bus  i_right,
    output pqmm_pkg::t_cell_bus       o_bus
);

    logic signed [pqmm_pkg::VALUE_WIDTH-1:0] r_val;
    logic signed [pqmm_pkg::VALUE_WIDTH-1:0] n_val;
    logic                                    r_vld;
    logic                                    n_vld;
    logic                                    w_above;

    // An empty cell ranks above any value, so inserts land at the first free place
    assign w_above = !r_vld || (r_val > i_ctl.value);

    assign o_bus.val   = r_val;
    assign o_bus.vld   = r_vld;
    assign o_bus.above = w_above;

    // Next entry for each row command
    always_comb begin
        n_val = r_val;
        n_vld = r_vld;
        unique case (i_ctl.op)
            pqmm_pkg::CELL_HOLD: begin
            end
            pqmm_pkg::CELL_INS: begin
                if (w_above) begin
                    if (i_left.above) begin
                        n_val = i_left.val;
                        n_vld = i_left.vld;
                    end else begin
                        n_val = i_ctl.value;
                        n_vld = 1'b1;
                    end
                end
            end
            pqmm_pkg::CELL_SHL: begin
                n_val = i_right.val;
                n_vld = i_right.vld;
            end
            pqmm_pkg::CELL_TRIM: begin
                n_vld = r_vld && i_right.vld;
            end
            pqmm_pkg::CELL_CLEAR: begin
                n_vld = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // Hold the entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    // Occupied cells form an unbroken run from cell 0
    `ASSERT_IMPLIES(a_cell_prefix, i_clk, i_rst_n, i_right.vld, r_vld)
    // A valid right neighbor never holds a smaller value than this cell
    `ASSERT_IMPLIES(a_cell_sorted, i_clk, i_rst_n, i_right.vld, !(r_val > i_right.val))

endmodule

`default_nettype wire

### sv/priority_queue_max_min_core.sv
// Top level of the priority queue: control, occupancy count and the row of cells.
`default_nettype none
`include "assert_macros.svh"

// Bounded priority queue of 64 signed 32-bit entries, kept sorted ascending in a
// row of cells; cell 0 holds the smallest entry, the last occupied cell the greatest.
// Each transaction is accepted into a command register, then the whole row inserts,
// shifts, trims or clears in parallel and the result is loaded into the output
// register. The next item is accepted while a result waits to be taken; the command
// waits only if the output register is still full and the output is stalled.
// The greatest entry is picked from the row into a register after each row update.
// order_mode may change with entries stored: the row stays sorted and only the end
// that is served changes. No clearing pass.
module priority_queue_max_min_core (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // configuration
    input  wire logic                                  i_cfg_we,
    input  wire logic                                  i_cfg_data,
    // input channel
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire logic [1:0]                            i_opcode,
    input  wire logic signed [pqmm_pkg::VALUE_WIDTH-1:0] i_value,
    // output channel
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output logic signed [pqmm_pkg::VALUE_WIDTH-1:0]    o_top_value,
    output logic                                       o_top_valid,
    output logic [1:0]                                 o_status,
    output logic [pqmm_pkg::CNT_W-1:0]                 o_occupancy
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state                                  r_state;
    t_state                                  n_state;
    logic                                    r_mode;
    logic [1:0]                              r_op;
    logic signed [pqmm_pkg::VALUE_WIDTH-1:0] r_value;
    logic [pqmm_pkg::CNT_W-1:0]              r_count;
    logic [pqmm_pkg::CNT_W-1:0]              n_count;
    logic signed [pqmm_pkg::VALUE_WIDTH-1:0] r_high;
    logic signed [pqmm_pkg::VALUE_WIDTH-1:0] w_high;

    logic                                    r_out_vld;
    logic signed [pqmm_pkg::VALUE_WIDTH-1:0] r_top_value;
    logic                                    r_top_valid;
    logic [1:0]                              r_status;
    logic signed [pqmm_pkg::VALUE_WIDTH-1:0] n_top_value;
    logic                                    n_top_valid;
    logic [1:0]                              n_status;

    logic                                    w_in_take;
    logic                                    w_proceed;
    pqmm_pkg::t_cell_ctl                     w_ctl;
    pqmm_pkg::t_cell_bus                     w_bus [pqmm_pkg::CAPACITY];
    pqmm_pkg::t_cell_bus                     w_edge_left;
    pqmm_pkg::t_cell_bus                     w_edge_right;
    logic [pqmm_pkg::CAPACITY-1:0]           w_vld;
    logic [pqmm_pkg::CAPACITY-1:0]           w_last;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_take   = i_in_valid && !o_in_stall;
    assign w_proceed   = (r_state == S_EXEC) && (!r_out_vld || !i_out_stall);

    assign o_out_valid = r_out_vld;
    assign o_top_value = r_top_value;
    assign o_top_valid = r_top_valid;
    assign o_status    = r_status;
    assign o_occupancy = r_count;

    // Row ends: nothing ranks above on the left, nothing stored on the right
    assign w_edge_left.val   = '0;
    assign w_edge_left.vld   = 1'b1;
    assign w_edge_left.above = 1'b0;
    assign w_edge_right.val   = '0;
    assign w_edge_right.vld   = 1'b0;
    assign w_edge_right.above = 1'b1;

    // Build the row of cells
    for (genvar g = 0; g < pqmm_pkg::CAPACITY; g++) begin : g_cell
        pqmm_pkg::t_cell_bus w_left;
        pqmm_pkg::t_cell_bus w_right;
        if (g == 0) begin : g_first
            assign w_left = w_edge_left;
        end else begin : g_mid_l
            assign w_left = w_bus[g-1];
        end
        if (g == pqmm_pkg::CAPACITY - 1) begin : g_final
            assign w_right = w_edge_right;
        end else begin : g_mid_r
            assign w_right = w_bus[g+1];
        end
        assign w_vld[g]  = w_bus[g].vld;
        assign w_last[g] = w_bus[g].vld && !w_right.vld;

        pqmm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_left  (w_left),
            .i_right (w_right),
            .o_bus   (w_bus[g])
        );
    end

    // Pick the greatest entry: the last occupied cell
    always_comb begin
        w_high = '0;
        for (int i = 0; i < pqmm_pkg::CAPACITY; i++) begin
            if (w_last[i]) begin
                w_high = w_high | w_bus[i].val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_high <= w_high;
    end

    // Decode the command into a row command, a result and the new count
    always_comb begin
        w_ctl.op    = pqmm_pkg::CELL_HOLD;
        w_ctl.value = r_value;
        n_count     = r_count;
        n_top_value = '0;
        n_top_valid = 1'b0;
        n_status    = pqmm_pkg::ST_OK;
        unique case (r_op) inside
            pqmm_pkg::OP_INSERT: begin
                if (r_count >= pqmm_pkg::CNT_MAX) begin
                    n_status = pqmm_pkg::ST_FULL;
                end else begin
                    w_ctl.op = pqmm_pkg::CELL_INS;
                    n_count  = r_count + 1'b1;
                end
            end
            pqmm_pkg::OP_REMOVE, pqmm_pkg::OP_PEEK: begin
                if (r_count == '0) begin
                    n_status = pqmm_pkg::ST_EMPTY;
                end else begin
                    n_top_valid = 1'b1;
                    n_top_value = r_mode ? w_bus[0].val : r_high;
                    if (r_op == pqmm_pkg::OP_REMOVE) begin
                        w_ctl.op = r_mode ? pqmm_pkg::CELL_SHL : pqmm_pkg::CELL_TRIM;
                        n_count  = r_count - 1'b1;
                    end
                end
            end
            pqmm_pkg::OP_CLEAR: begin
                w_ctl.op = pqmm_pkg::CELL_CLEAR;
                n_count  = '0;
            end
            default: begin
            end
        endcase
        if (!w_proceed) begin
            w_ctl.op = pqmm_pkg::CELL_HOLD;
            n_count  = r_count;
        end
    end

    // Sequence: accept, then execute once the output register is free
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_take) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_proceed) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_mode    <= 1'b0;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
            if (w_proceed) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Capture the transaction and the result payload
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_op    <= i_opcode;
            r_value <= i_value;
        end
        if (w_proceed) begin
            r_top_value <= n_top_value;
            r_top_valid <= n_top_valid;
            r_status    <= n_status;
        end
    end

    `ASSERT_IMPLIES(a_count_cells, i_clk, i_rst_n, 1'b1, $countones(w_vld) == r_count)
    `ASSERT_IMPLIES(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= pqmm_pkg::CNT_MAX)
    `ASSERT_IMPLIES(a_valid_ok, i_clk, i_rst_n, r_out_vld && r_top_valid, r_status == pqmm_pkg::ST_OK)
    `ASSERT_NEXT(a_take_exec, i_clk, i_rst_n, w_in_take, r_state == S_EXEC)

endmodule

`default_nettype wire
